/* hw/rtl/oal_pkg.sv */
// oal_pkg: shared types and constants for the ordered array list
// request codes, status codes, cell command and group result structs
// no dependencies
package oal_pkg;

    // default list capacity
    localparam int DEPTH_DEFAULT = 128;

    // cells per reduction group (power of two)
    localparam int GRP_IW   = 4;
    localparam int GRP_SIZE = 1 << GRP_IW;

    // request codes
    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_DELETE = 3'd1,
        K_READ   = 3'd2,
        K_FIND   = 3'd3,
        K_CLEAR  = 3'd4
    } kind_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
        logic fnd;
    } cell_cmd_t;

    // first hit within one group of cells
    typedef struct packed {
        logic               any;
        logic [GRP_IW-1:0]  idx;
        logic signed [31:0] data;
    } grp_res_t;

endpackage

/* hw/rtl/oal_cell.sv */
// oal_cell: one entry of the list, shifts with its neighbors and flags hits
// depends on oal_pkg
module oal_cell #(
    parameter int IDX = 0,
    parameter int WW  = 9
) (
    input  logic               clk,
    input  oal_pkg::cell_cmd_t cmd,
    input  logic [WW-1:0]      p,
    input  logic [WW-1:0]      cnt,
    input  logic signed [31:0] value,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    output logic signed [31:0] data,
    output logic               hit
);
    import oal_pkg::*;

    localparam logic [WW-1:0] IDX_W = WW'(IDX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               hit_reg;
    logic               hit_next;

    // insert opens a slot at p, delete closes it
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (IDX_W == p)
                data_next = value;
            else if (IDX_W > p)
                data_next = left_data;
        end
        else if (cmd.del)
        begin
            if (IDX_W >= p)
                data_next = right_data;
        end
    end

    // hit for read at this slot or for a matching live entry
    always_comb
    begin
        hit_next = (cmd.rd && (IDX_W == p))
                || (cmd.fnd && (data_reg == value) && (IDX_W < cnt));
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

/* hw/rtl/oal_group.sv */
// oal_group: lowest-index hit among one group of cells
// depends on oal_pkg
module oal_group (
    input  logic [oal_pkg::GRP_SIZE-1:0] hit,
    input  logic signed [31:0]           data [oal_pkg::GRP_SIZE],
    output oal_pkg::grp_res_t            res
);
    import oal_pkg::*;

    // scan from the top so the lowest hit wins
    always_comb
    begin
        res = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                res.any  = 1'b1;
                res.idx  = GRP_IW'(i);
                res.data = data[i];
            end
        end
    end

endmodule

/* hw/rtl/ordered_array_list_top.sv */
// ordered_array_list_top: ordered list held in a chain of shifting cells
// depends on oal_pkg, oal_cell, oal_group
//
//   channel | signals                                   | dir
//   req     | req_valid, req_ready, kind, position, value | in
//   rsp     | rsp_valid, rsp_ready, status, found_position,
//           | read_value, list_length                   | out
//
// insert, delete, clear, rejected: result loaded when taken; insert and delete
// shift all cells together; read and find: hit flags in the cells, then a group
// stage, then the pick over groups; one request in flight at a time
// reset empties the list; stored entries are not cleared
// req_ready stays low while a request is in flight or the result is not taken
module ordered_array_list_top #(
    parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [2:0]         kind,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [1:0]         status,
    output logic [7:0]         found_position,
    output logic signed [31:0] read_value,
    output logic [7:0]         list_length
);
    import oal_pkg::*;

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int WW  = ((CW > 8) ? CW : 8) + 1;
    localparam int NG  = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NGW = (NG > 1) ? $clog2(NG) : 1;
    localparam int NC  = NG * GRP_SIZE;
    localparam int FW  = NGW + GRP_IW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PICK
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               is_find_reg, is_find_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [7:0]         found_reg, found_next;
    logic signed [31:0] rdata_reg, rdata_next;
    logic [7:0]         len_reg, len_next;
    grp_res_t           grp_reg [NG];

    logic               req_fire;
    logic [WW-1:0]      pos_w;
    logic [WW-1:0]      cnt_w;
    logic [WW-1:0]      p;
    logic               pos_ok_ins;
    logic               pos_ok;
    logic               full;
    cell_cmd_t          cmd;

    logic signed [31:0] cell_data [NC];
    logic [NC-1:0]      hit_vec;
    grp_res_t           grp_res [NG];

    // request decode
    assign req_ready  = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire   = req_valid && req_ready;
    assign pos_w      = WW'(position);
    assign cnt_w      = WW'(count_reg);
    assign p          = pos_w - WW'(1);
    assign pos_ok_ins = (pos_w != '0) && (pos_w <= cnt_w + WW'(1));
    assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
    assign full       = (count_reg == CW'(DEPTH));

    assign cmd.ins = req_fire && (kind == K_INSERT) && pos_ok_ins && !full;
    assign cmd.del = req_fire && (kind == K_DELETE) && pos_ok;
    assign cmd.rd  = req_fire && (kind == K_READ) && pos_ok;
    assign cmd.fnd = req_fire && (kind == K_FIND);

    // chain of cells, padded with empty slots up to whole groups
    for (genvar j = 0; j < NC; j++)
    begin : g_cell
        if (j < DEPTH)
        begin : g_live
            logic signed [31:0] left_d;
            logic signed [31:0] right_d;
            assign left_d  = (j == 0) ? value : cell_data[(j == 0) ? 0 : j - 1];
            assign right_d = (j == DEPTH - 1) ? cell_data[j]
                                              : cell_data[(j == DEPTH - 1) ? j : j + 1];
            oal_cell #(
                .IDX (j),
                .WW  (WW)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .p          (p),
                .cnt        (cnt_w),
                .value      (value),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[j]),
                .hit        (hit_vec[j])
            );
        end
        else
        begin : g_pad
            assign cell_data[j] = '0;
            assign hit_vec[j]   = 1'b0;
        end
    end

    // first hit within each group
    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        logic signed [31:0] grp_data [GRP_SIZE];

        for (genvar i = 0; i < GRP_SIZE; i++)
        begin : g_tap
            assign grp_data[i] = cell_data[g*GRP_SIZE + i];
        end

        oal_group u_group (
            .hit  (hit_vec[g*GRP_SIZE +: GRP_SIZE]),
            .data (grp_data),
            .res  (grp_res[g])
        );
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_reg[g] <= grp_res[g];
        end
    end

    // control, list length and result register
    always_comb
    begin
        logic             any;
        logic [NGW-1:0]   gsel;
        grp_res_t         gres;
        logic [FW-1:0]    fidx;

        state_next     = state_reg;
        count_next     = count_reg;
        is_find_next   = is_find_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        rdata_next     = rdata_reg;
        len_next       = len_reg;
        any            = 1'b0;
        gsel           = '0;
        gres           = '0;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        // pick the lowest group with a hit
        for (int g = NG - 1; g >= 0; g--)
        begin
            if (grp_reg[g].any)
            begin
                any  = 1'b1;
                gsel = NGW'(g);
                gres = grp_reg[g];
            end
        end
        fidx = {1'b0, gsel, gres.idx} + FW'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    status_next = ST_OK;
                    found_next  = '0;
                    rdata_next  = '0;
                    unique case (kind)
                        K_INSERT:
                        begin
                            if (!pos_ok_ins)
                                status_next = ST_RANGE;
                            else if (full)
                                status_next = ST_FULL;
                            else
                                count_next = count_reg + CW'(1);
                        end
                        K_DELETE:
                        begin
                            if (!pos_ok)
                                status_next = ST_RANGE;
                            else
                                count_next = count_reg - CW'(1);
                        end
                        K_READ:
                        begin
                            if (!pos_ok)
                                status_next = ST_RANGE;
                        end
                        K_FIND:
                        begin
                        end
                        K_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    len_next = 8'(count_next);
                    if (cmd.rd || cmd.fnd)
                    begin
                        state_next   = S_SCAN;
                        is_find_next = cmd.fnd;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                state_next = S_PICK;
            end
            S_PICK:
            begin
                state_next     = S_IDLE;
                rsp_valid_next = 1'b1;
                len_next       = 8'(count_reg);
                if (is_find_reg)
                begin
                    status_next = any ? ST_OK : ST_NOT_FOUND;
                    found_next  = any ? 8'(fidx) : 8'd0;
                    rdata_next  = '0;
                end
                else
                begin
                    status_next = ST_OK;
                    found_next  = '0;
                    rdata_next  = gres.data;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            is_find_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= '0;
            found_reg     <= '0;
            rdata_reg     <= '0;
            len_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            is_find_reg   <= is_find_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            rdata_reg     <= rdata_next;
            len_reg       <= len_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign read_value     = rdata_reg;
    assign list_length    = len_reg;

endmodule

/* tb/sv/tb.sv */
// tb: self-checking testbench for ordered_array_list_top
// depends on oal_pkg, ordered_array_list_top; each response checked by shadow list or row
module tb;

    import oal_pkg::*;

    localparam int LIST_DEPTH    = oal_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_PRINTED   = 50;

    // request codes the block ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // shapes of random request streams
    localparam int PROFILE_FILL  = 0;
    localparam int PROFILE_MIXED = 1;
    localparam int PROFILE_DRAIN = 2;

    typedef struct packed {
        status_t            st;
        logic [7:0]         fpos;
        logic signed [31:0] rval;
        logic [7:0]         len;
    } list_result_t;

    typedef struct {
        logic [2:0]         k;
        logic [7:0]         p;
        logic signed [31:0] v;
        bit                 has_exp;
        list_result_t       exp;
    } request_row_t;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_ready;
    logic [2:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
    logic               rsp_valid;
    logic               rsp_ready;
    logic [1:0]         status;
    logic [7:0]         found_position;
    logic signed [31:0] read_value;
    logic [7:0]         list_length;

    // typed expectation travels with the payload of a directed row
    bit                 row_has_exp;
    list_result_t       row_exp;

    // shadow copy of the list
    logic signed [31:0] shadow_cells [LIST_DEPTH];
    int                 shadow_len;

    list_result_t       pending_results [$];
    request_row_t       directed_rows [$];

    int  error_count;
    int  requests_accepted;
    int  results_checked;
    int  status_seen [4];
    int  longest_list;
    int  cycle_count;
    bit  no_idle;
    bit  rx_hold_request;
    int  rx_holds_done;

    ordered_array_list_top #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .kind           (kind),
        .position       (position),
        .value          (value),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .found_position (found_position),
        .read_value     (read_value),
        .list_length    (list_length)
    );

    // clock, period 4
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // apply one request to the shadow list and return its response
    function automatic list_result_t apply_request(input logic [2:0] k, input logic [7:0] p,
                                                   input logic signed [31:0] v);
        list_result_t r;
        int           pi;
        int           j;
        bit           hit;
        r.st   = ST_OK;
        r.fpos = 8'd0;
        r.rval = 32'sd0;
        pi     = p;
        hit    = 1'b0;
        case (k)
            K_INSERT:
            begin
                if (pi < 1 || pi > shadow_len + 1)
                    r.st = ST_RANGE;
                else if (shadow_len >= LIST_DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    for (j = shadow_len; j > pi - 1; j--)
                        shadow_cells[j] = shadow_cells[j - 1];
                    shadow_cells[pi - 1] = v;
                    shadow_len++;
                end
            end
            K_DELETE:
            begin
                if (pi < 1 || pi > shadow_len)
                    r.st = ST_RANGE;
                else
                begin
                    for (j = pi - 1; j + 1 < shadow_len; j++)
                        shadow_cells[j] = shadow_cells[j + 1];
                    shadow_len--;
                end
            end
            K_READ:
            begin
                if (pi < 1 || pi > shadow_len)
                    r.st = ST_RANGE;
                else
                    r.rval = shadow_cells[pi - 1];
            end
            K_FIND:
            begin
                r.st = ST_NOT_FOUND;
                for (j = 0; j < shadow_len && !hit; j++)
                begin
                    if (shadow_cells[j] == v)
                    begin
                        hit    = 1'b1;
                        r.fpos = 8'(j + 1);
                        r.st   = ST_OK;
                    end
                end
            end
            K_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        r.len = 8'(shadow_len);
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTED)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // predict on request transfer, compare on response transfer
    always @(posedge clk)
    begin : result_check
        list_result_t predicted;
        list_result_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predicted = apply_request(kind, position, value);
                pending_results.push_back(row_has_exp ? row_exp : predicted);
                requests_accepted++;
                if (shadow_len > longest_list)
                    longest_list = shadow_len;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                    report_error("response with no request waiting");
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                        report_error($sformatf("response %0d status %0d, want %0d",
                                               results_checked, status, want.st));
                    if (found_position !== want.fpos)
                        report_error($sformatf("response %0d found_position %0d, want %0d",
                                               results_checked, found_position, want.fpos));
                    if (read_value !== want.rval)
                        report_error($sformatf("response %0d read_value %0d, want %0d",
                                               results_checked, read_value, want.rval));
                    if (list_length !== want.len)
                        report_error($sformatf("response %0d list_length %0d, want %0d",
                                               results_checked, list_length, want.len));
                    status_seen[want.st]++;
                end
                results_checked++;
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // response side: random stalls, one long hold-off on request
    initial
    begin : response_side
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                rx_holds_done++;
                rsp_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one request and hold it until the transfer
    task automatic send_request(input logic [2:0] k, input logic [7:0] p,
                                input logic signed [31:0] v, input bit has_exp,
                                input list_result_t exp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        kind        <= k;
        position    <= p;
        value       <= v;
        row_has_exp <= has_exp;
        row_exp     <= exp;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] k, input logic [7:0] p,
                           input logic signed [31:0] v);
        request_row_t row;
        row.k       = k;
        row.p       = p;
        row.v       = v;
        row.has_exp = 1'b0;
        row.exp     = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_checked_row(input logic [2:0] k, input logic [7:0] p,
                                   input logic signed [31:0] v, input status_t st,
                                   input logic [7:0] fpos, input logic signed [31:0] rval,
                                   input logic [7:0] len);
        request_row_t row;
        row.k        = k;
        row.p        = p;
        row.v        = v;
        row.has_exp  = 1'b1;
        row.exp.st   = st;
        row.exp.fpos = fpos;
        row.exp.rval = rval;
        row.exp.len  = len;
        directed_rows.push_back(row);
    endtask

    function automatic logic [2:0] pick_kind(input int profile);
        int r;
        r = $urandom_range(0, 99);
        case (profile)
            PROFILE_FILL:
            begin
                if (r < 80) return K_INSERT;
                if (r < 88) return K_READ;
                if (r < 96) return K_FIND;
                return K_DELETE;
            end
            PROFILE_DRAIN:
            begin
                if (r < 85) return K_DELETE;
                if (r < 93) return K_READ;
                return K_FIND;
            end
            default:
            begin
                if (r < 31) return K_INSERT;
                if (r < 56) return K_DELETE;
                if (r < 75) return K_READ;
                if (r < 95) return K_FIND;
                if (r < 96) return K_CLEAR;
                return 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            end
        endcase
    endfunction

    // mostly legal positions, some zero, some just past the end, some anywhere
    function automatic logic [7:0] pick_position(input logic [2:0] k);
        int lim;
        int r;
        lim = (k == K_INSERT) ? shadow_len + 1 : shadow_len;
        r   = $urandom_range(0, 99);
        if (r < 82)
            return (lim >= 1) ? 8'($urandom_range(1, lim)) : 8'd1;
        else if (r < 88)
            return 8'd0;
        else if (r < 94)
            return (lim + 1 > 255) ? 8'd255 : 8'(lim + 1);
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // small pool for duplicates, extremes, or anything
    function automatic logic signed [31:0] pick_value(input logic [2:0] k);
        int r;
        r = $urandom_range(0, 99);
        if (k == K_FIND && shadow_len > 0 && r < 60)
            return shadow_cells[$urandom_range(0, shadow_len - 1)];
        r = $urandom_range(0, 99);
        if (r < 25)
            return $signed(32'($urandom_range(0, 7))) - 32'sd3;
        else if (r < 35)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        else
            return $signed($urandom);
    endfunction

    task automatic run_random(input int profile, input int count);
        logic [2:0] k;
        int         i;
        for (i = 0; i < count; i++)
        begin
            k = pick_kind(profile);
            send_request(k, pick_position(k), pick_value(k), 1'b0, '0);
        end
    endtask

    task automatic wait_all_results();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int i;
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        kind            = K_INSERT;
        position        = 8'd0;
        value           = 32'sd0;
        row_has_exp     = 1'b0;
        row_exp         = '0;
        no_idle         = 1'b0;
        rx_hold_request = 1'b0;
        shadow_len      = 0;
        for (i = 0; i < LIST_DEPTH; i++)
            shadow_cells[i] = 32'sd0;

        // empty list rejects, extremes, first-match find, ignored codes, clear
        add_checked_row(K_READ,   8'd1,   32'sd0,         ST_RANGE,     8'd0, 32'sd0, 8'd0);
        add_checked_row(K_DELETE, 8'd0,   32'sd0,         ST_RANGE,     8'd0, 32'sd0, 8'd0);
        add_checked_row(K_FIND,   8'd0,   32'sd0,         ST_NOT_FOUND, 8'd0, 32'sd0, 8'd0);
        add_checked_row(K_INSERT, 8'd2,   32'sd5,         ST_RANGE,     8'd0, 32'sd0, 8'd0);
        add_checked_row(K_INSERT, 8'd0,   32'sd5,         ST_RANGE,     8'd0, 32'sd0, 8'd0);
        add_checked_row(K_INSERT, 8'd1,   32'sh7fffffff,  ST_OK,        8'd0, 32'sd0, 8'd1);
        add_checked_row(K_INSERT, 8'd1,   32'sh80000000,  ST_OK,        8'd0, 32'sd0, 8'd2);
        add_checked_row(K_INSERT, 8'd3,   -32'sd1,        ST_OK,        8'd0, 32'sd0, 8'd3);
        add_checked_row(K_READ,   8'd1,   32'sd0,         ST_OK,        8'd0, 32'sh80000000, 8'd3);
        add_checked_row(K_READ,   8'd3,   32'sd0,         ST_OK,        8'd0, -32'sd1, 8'd3);
        add_checked_row(K_READ,   8'd4,   32'sd0,         ST_RANGE,     8'd0, 32'sd0, 8'd3);
        add_checked_row(K_FIND,   8'd0,   32'sh7fffffff,  ST_OK,        8'd2, 32'sd0, 8'd3);
        add_row(K_INSERT, 8'd2, -32'sd1);
        add_checked_row(K_FIND,   8'hff,  -32'sd1,        ST_OK,        8'd2, 32'sd0, 8'd4);
        add_checked_row(K_INSERT, 8'd255, 32'sd9,         ST_RANGE,     8'd0, 32'sd0, 8'd4);
        add_checked_row(K_READ,   8'd255, 32'sd0,         ST_RANGE,     8'd0, 32'sd0, 8'd4);
        add_checked_row(KIND_SPARE_LO,     8'd255, -32'sd1, ST_OK, 8'd0, 32'sd0, 8'd4);
        add_checked_row(KIND_SPARE_LO + 3'd1, 8'd1, 32'sd0, ST_OK, 8'd0, 32'sd0, 8'd4);
        add_checked_row(KIND_SPARE_HI,     8'd2,   32'sd7,  ST_OK, 8'd0, 32'sd0, 8'd4);
        add_checked_row(K_DELETE, 8'd4,   32'sd0,         ST_OK,        8'd0, 32'sd0, 8'd3);
        add_row(K_DELETE, 8'd1, 32'sd0);
        add_row(K_READ,   8'd1, 32'sd0);
        add_checked_row(K_DELETE, 8'd3,   32'sd0,         ST_RANGE,     8'd0, 32'sd0, 8'd2);
        add_checked_row(K_CLEAR,  8'd0,   32'sd0,         ST_OK,        8'd0, 32'sd0, 8'd0);
        // stale entries after clear must not match
        add_checked_row(K_FIND,   8'd0,   -32'sd1,        ST_NOT_FOUND, 8'd0, 32'sd0, 8'd0);
        add_checked_row(K_READ,   8'd1,   32'sd0,         ST_RANGE,     8'd0, 32'sd0, 8'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[n])
            send_request(directed_rows[n].k, directed_rows[n].p, directed_rows[n].v,
                         directed_rows[n].has_exp, directed_rows[n].exp);

        // fill past capacity, then mixed traffic
        run_random(PROFILE_FILL, 260);
        run_random(PROFILE_MIXED, 200);

        // sender idles until the block has answered everything
        req_valid <= 1'b0;
        wait_all_results();
        @(posedge clk);

        // long receiver hold-off while requests keep coming
        rx_hold_request = 1'b1;
        run_random(PROFILE_MIXED, 300);
        run_random(PROFILE_FILL, 150);
        run_random(PROFILE_DRAIN, 180);

        // back-to-back stretch with no sender idling
        no_idle = 1'b1;
        run_random(PROFILE_FILL, 60);
        run_random(PROFILE_MIXED, 100);
        no_idle = 1'b0;

        req_valid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d responses never arrived", pending_results.size()));

        $display("%0d requests, %0d responses checked in %0d cycles, longest list %0d",
                 requests_accepted, results_checked, cycle_count, longest_list);
        $display("ok %0d, out of range %0d, full %0d, not found %0d, receiver holds %0d",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL],
                 status_seen[ST_NOT_FOUND], rx_holds_done);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
